[design/tick_event_scheduler_macros.svh]
// assertion macros for the tick event scheduler
`ifndef TICK_EVENT_SCHEDULER_MACROS_SVH
`define TICK_EVENT_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define TES_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tick event scheduler check failed");
`define TES_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tick event scheduler check failed");
`else
`define TES_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define TES_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

[design/tes_pkg.sv]
// shared types and constants of the tick event scheduler
package tes_pkg;

    localparam int READY_DEPTH = 8;
    localparam int DELAY_DEPTH = 8;
    localparam int RQ_IDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int RQ_CNT_W = $clog2(READY_DEPTH + 1);
    localparam int DL_IDX_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int DL_CNT_W = $clog2(DELAY_DEPTH + 1);

    localparam int ACC_W     = 17;
    localparam int SACC_W    = 32;
    localparam int LEFT_W    = 28;
    localparam int BATCH_W   = 13;
    localparam int DIV_W     = 31;
    localparam int REM_W     = 7;
    localparam int PROD_W    = DIV_W + 32;
    localparam int DAY_W     = 17;
    localparam int CODE_W    = 8;
    localparam int PULSE_W   = 5;
    localparam int PHASE_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [SACC_W-1:0] SACC_MAX = {SACC_W{1'b1}};
    localparam logic [ACC_W-1:0]  HUND_MS  = 17'd10;
    localparam logic [ACC_W-1:0]  TENTH_MS = 17'd100;
    localparam logic [SACC_W-1:0] SEC_MS   = 32'd1000;
    localparam logic [REM_W-1:0]  DIV_TEN     = 7'd10;
    localparam logic [REM_W-1:0]  DIV_HUNDRED = 7'd100;
    localparam logic [31:0]       RECIP_TEN     = 32'hCCCC_CCCD;
    localparam logic [31:0]       RECIP_HUNDRED = 32'h51EB_851F;
    localparam int                SHIFT_TEN     = 35;
    localparam int                SHIFT_HUNDRED = 37;
    localparam logic [DAY_W-1:0]  DAY_LAST    = 17'd86399;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd9;

    localparam logic [1:0] MODE_POLL   = 2'd0;
    localparam logic [1:0] MODE_PUSH   = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_HUND  = 3'd1;
    localparam logic [2:0] KIND_TENTH = 3'd2;
    localparam logic [2:0] KIND_SEC   = 3'd3;
    localparam logic [2:0] KIND_USER  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DAY   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_POLL, S_CHECK, S_HDIV, S_CD, S_TDIV, S_DAY, S_POP,
        S_DSTART, S_DROP, S_PUSH_DEC, S_PDIV, S_FIN
    } t_state;

    typedef enum logic [1:0] {C_CD, C_DAY, C_PUSH, C_REMOVE} t_ctx;
    typedef enum logic [1:0] {DIV_HUND, DIV_TENTH, DIV_DELAY} t_div_sel;
    typedef enum logic [1:0] {CODE_ITEM, CODE_DAY, CODE_ENTRY} t_code_sel;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] elapsed_ms;
        logic [7:0]  event_code;
        logic [30:0] delay_ms;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  user_code;
        logic [12:0] tick_batch;
        logic        led_on;
        logic [31:0] seconds_count;
        logic        accepted;
    } t_out_beat;

    typedef struct packed {
        logic      load_item;
        logic      accum_add;
        logic      div_start;
        t_div_sel  div_sel;
        logic      apply_hund;
        logic      apply_tenth;
        logic      apply_sec;
        logic      pop_ready;
        logic      drop_start;
        t_code_sel code_sel;
        logic      drop_step;
        logic      drop_end;
        logic      sel_drop;
        logic      ready_push;
        logic      set_accept;
        logic      reject;
        logic      cd_step;
        logic      store_delay;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       e_nz;
        logic       h_ge;
        logic       t_ge;
        logic       s_ge;
        logic       day_hit;
        logic       ready_nz;
        logic       delay_full;
        logic       delay_zero;
        logic       div_busy;
        logic       drop_more;
        logic       cd_more;
        logic       cd_expired;
    } t_dp_stat;

endpackage

[design/tes_div.sv]
// divider by ten or one hundred through a reciprocal multiply: the product is registered, then quotient and remainder
module tes_div import tes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [REM_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quot,
    output logic [REM_W-1:0] o_rem
);

    logic [1:0]        r_cnt;
    logic [DIV_W-1:0]  r_x;
    logic              r_hund;
    logic [PROD_W-1:0] r_prod;
    logic [DIV_W-1:0]  r_q;
    logic [REM_W-1:0]  r_rem;
    logic [31:0]       w_recip;
    logic [DIV_W-1:0]  w_q;
    logic [REM_W-1:0]  w_qd;

    assign w_recip = r_hund ? RECIP_HUNDRED : RECIP_TEN;
    assign w_q     = r_hund ? DIV_W'(r_prod >> SHIFT_HUNDRED) : DIV_W'(r_prod >> SHIFT_TEN);

    // low bits of quotient times divisor, enough for a remainder below 128
    assign w_qd = r_hund ? REM_W'({w_q[REM_W-1:0], 6'b0} + {w_q[REM_W-1:0], 5'b0}
                                  + {w_q[REM_W-1:0], 2'b0})
                         : REM_W'({w_q[REM_W-1:0], 3'b0} + {w_q[REM_W-1:0], 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 2'd2;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_dividend;
            r_hund <= i_divisor == DIV_HUNDRED;
        end
        if (r_cnt == 2'd2) begin
            r_prod <= PROD_W'(r_x) * PROD_W'(w_recip);
        end
        if (r_cnt == 2'd1) begin
            r_q   <= w_q;
            r_rem <= r_x[REM_W-1:0] - w_qd;
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

[design/tes_datapath.sv]
// scheduler datapath: accumulators, counters, immediate queue and delayed table
module tes_datapath import tes_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_beat              i_in_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_out_beat             o_result
);

    logic [PULSE_W-1:0] r_pulse;
    logic [CODE_W-1:0]  r_day_code;
    logic [1:0]         r_mode;
    logic [15:0]        r_elapsed;
    logic [CODE_W-1:0]  r_code;
    logic [30:0]        r_delay;

    logic [ACC_W-1:0]   r_h_acc;
    logic [ACC_W-1:0]   r_t_acc;
    logic [SACC_W-1:0]  r_s_acc;
    logic [PHASE_W-1:0] r_phase;
    logic [31:0]        r_seconds;
    logic               r_led;
    logic [DAY_W-1:0]   r_day_cnt;

    logic [2:0]         r_kind;
    logic [CODE_W-1:0]  r_ucode;
    logic [BATCH_W-1:0] r_batch;
    logic               r_accept;

    logic [CODE_W-1:0]  r_rq [READY_DEPTH];
    logic [RQ_CNT_W-1:0] r_rcount;
    logic [CODE_W-1:0]  r_dcodes [DELAY_DEPTH];
    logic [LEFT_W-1:0]  r_dleft [DELAY_DEPTH];
    logic [DL_CNT_W-1:0] r_dcount;
    logic [DL_CNT_W-1:0] r_rd;
    logic [DL_CNT_W-1:0] r_wr;
    logic [DL_CNT_W-1:0] r_ci;
    logic [CODE_W-1:0]  r_drop_code;

    logic [ACC_W:0]     w_h_sum;
    logic [ACC_W:0]     w_t_sum;
    logic [SACC_W:0]    w_s_sum;
    logic [ACC_W-1:0]   n_h_acc;
    logic [ACC_W-1:0]   n_t_acc;
    logic [SACC_W-1:0]  n_s_acc;
    logic [DL_IDX_W-1:0] w_addr;
    logic [CODE_W-1:0]  w_ent_code;
    logic [LEFT_W-1:0]  w_ent_left;
    logic [CODE_W-1:0]  w_sel_code;
    logic [DIV_W-1:0]   w_dividend;
    logic [REM_W-1:0]   w_divisor;
    logic               w_busy;
    logic [DIV_W-1:0]   w_quot;
    logic [REM_W-1:0]   w_rem;
    logic [31:0]        w_sec_next;
    logic [PHASE_W-1:0] w_phase_next;
    logic [LEFT_W-1:0]  w_h_left;
    logic               w_rq_room;
    logic               w_keep;

    assign w_h_sum = {1'b0, r_h_acc} + (ACC_W+1)'(r_elapsed);
    assign w_t_sum = {1'b0, r_t_acc} + (ACC_W+1)'(r_elapsed);
    assign w_s_sum = {1'b0, r_s_acc} + (SACC_W+1)'(r_elapsed);
    assign n_h_acc = w_h_sum[ACC_W] ? ACC_MAX : w_h_sum[ACC_W-1:0];
    assign n_t_acc = w_t_sum[ACC_W] ? ACC_MAX : w_t_sum[ACC_W-1:0];
    assign n_s_acc = w_s_sum[SACC_W] ? SACC_MAX : w_s_sum[SACC_W-1:0];

    assign w_addr     = i_cmd.sel_drop ? r_rd[DL_IDX_W-1:0] : r_ci[DL_IDX_W-1:0];
    assign w_ent_code = r_dcodes[w_addr];
    assign w_ent_left = r_dleft[w_addr];
    assign w_keep     = w_ent_code != r_drop_code;

    always_comb begin
        case (i_cmd.code_sel)
            CODE_ITEM:  w_sel_code = r_code;
            CODE_DAY:   w_sel_code = r_day_code;
            CODE_ENTRY: w_sel_code = w_ent_code;
            default:    w_sel_code = r_code;
        endcase
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_HUND: begin
                w_dividend = DIV_W'(r_h_acc);
                w_divisor  = DIV_TEN;
            end
            DIV_TENTH: begin
                w_dividend = DIV_W'(r_t_acc);
                w_divisor  = DIV_HUNDRED;
            end
            default: begin
                w_dividend = r_delay;
                w_divisor  = DIV_TEN;
            end
        endcase
    end

    tes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_sec_next   = r_seconds + 32'd1;
    assign w_phase_next = (r_phase >= PHASE_LAST) ? '0 : r_phase + 1'b1;
    assign w_h_left     = (w_quot[LEFT_W-1:0] == '0) ? LEFT_W'(1) : w_quot[LEFT_W-1:0];
    assign w_rq_room    = r_rcount < RQ_CNT_W'(READY_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse    <= '0;
            r_day_code <= '1;
            r_h_acc    <= '0;
            r_t_acc    <= '0;
            r_s_acc    <= '0;
            r_phase    <= '0;
            r_seconds  <= '0;
            r_led      <= 1'b0;
            r_day_cnt  <= '0;
            r_rcount   <= '0;
            r_dcount   <= '0;
            r_rd       <= '0;
            r_wr       <= '0;
            r_ci       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PULSE: r_pulse    <= i_cfg_data[PULSE_W-1:0];
                    REG_DAY:   r_day_code <= i_cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accum_add) begin
                r_h_acc <= n_h_acc;
                r_t_acc <= n_t_acc;
                r_s_acc <= n_s_acc;
            end
            if (i_cmd.apply_hund) begin
                r_h_acc <= ACC_W'(w_rem);
                r_ci    <= '0;
            end
            if (i_cmd.apply_tenth) begin
                r_phase <= w_phase_next;
                r_t_acc <= ACC_W'(w_rem);
                if ({1'b0, w_phase_next} >= r_pulse) begin
                    r_led <= 1'b0;
                end
            end
            if (i_cmd.apply_sec) begin
                r_s_acc   <= r_s_acc - SEC_MS;
                r_seconds <= w_sec_next;
                if (r_pulse != '0) begin
                    r_led <= 1'b1;
                end
                if (w_sec_next == '0 || r_day_cnt == DAY_LAST) begin
                    r_day_cnt <= '0;
                end else begin
                    r_day_cnt <= r_day_cnt + 1'b1;
                end
            end
            if (i_cmd.pop_ready) begin
                r_rcount <= r_rcount - 1'b1;
            end
            if (i_cmd.drop_start) begin
                r_rd <= '0;
                r_wr <= '0;
            end
            if (i_cmd.drop_step) begin
                r_rd <= r_rd + 1'b1;
                if (w_keep) begin
                    r_wr <= r_wr + 1'b1;
                end
            end
            if (i_cmd.drop_end) begin
                r_dcount <= r_wr;
            end
            if (i_cmd.ready_push && w_rq_room) begin
                r_rcount <= r_rcount + 1'b1;
            end
            if (i_cmd.cd_step) begin
                r_ci <= r_ci + 1'b1;
            end
            if (i_cmd.store_delay) begin
                r_dcount <= r_dcount + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode    <= i_in_beat.mode;
            r_elapsed <= i_in_beat.elapsed_ms;
            r_code    <= i_in_beat.event_code;
            r_delay   <= i_in_beat.delay_ms;
            r_kind    <= KIND_NONE;
            r_ucode   <= '0;
            r_batch   <= '0;
            r_accept  <= 1'b1;
        end
        if (i_cmd.apply_hund) begin
            r_kind  <= KIND_HUND;
            r_batch <= w_quot[BATCH_W-1:0];
        end
        if (i_cmd.apply_tenth) begin
            r_kind  <= KIND_TENTH;
            r_batch <= w_quot[BATCH_W-1:0];
        end
        if (i_cmd.apply_sec) begin
            r_kind  <= KIND_SEC;
            r_batch <= BATCH_W'(1);
        end
        if (i_cmd.pop_ready) begin
            r_kind  <= KIND_USER;
            r_ucode <= r_rq[0];
            for (int i = 0; i < READY_DEPTH - 1; i++) begin
                r_rq[i] <= r_rq[i+1];
            end
        end
        if (i_cmd.drop_start) begin
            r_drop_code <= w_sel_code;
        end
        if (i_cmd.drop_step && w_keep) begin
            r_dcodes[r_wr[DL_IDX_W-1:0]] <= w_ent_code;
            r_dleft[r_wr[DL_IDX_W-1:0]]  <= w_ent_left;
        end
        if (i_cmd.ready_push) begin
            if (w_rq_room) begin
                r_rq[r_rcount[RQ_IDX_W-1:0]] <= r_drop_code;
            end
            if (i_cmd.set_accept) begin
                r_accept <= w_rq_room;
            end
        end
        if (i_cmd.reject) begin
            r_accept <= 1'b0;
        end
        if (i_cmd.cd_step) begin
            r_dleft[w_addr] <= w_ent_left - LEFT_W'(r_batch);
        end
        if (i_cmd.store_delay) begin
            r_dcodes[r_dcount[DL_IDX_W-1:0]] <= r_code;
            r_dleft[r_dcount[DL_IDX_W-1:0]]  <= w_h_left;
        end
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.e_nz       = r_elapsed != '0;
        o_stat.h_ge       = r_h_acc >= HUND_MS;
        o_stat.t_ge       = r_t_acc >= TENTH_MS;
        o_stat.s_ge       = r_s_acc >= SEC_MS;
        o_stat.day_hit    = r_day_cnt == '0;
        o_stat.ready_nz   = r_rcount != '0;
        o_stat.delay_full = r_dcount >= DL_CNT_W'(DELAY_DEPTH);
        o_stat.delay_zero = r_delay == '0;
        o_stat.div_busy   = w_busy;
        o_stat.drop_more  = r_rd < r_dcount;
        o_stat.cd_more    = r_ci < r_dcount;
        o_stat.cd_expired = w_ent_left <= LEFT_W'(r_batch);
    end

    always_comb begin
        o_result.event_kind    = r_kind;
        o_result.user_code     = r_ucode;
        o_result.tick_batch    = r_batch;
        o_result.led_on        = r_led;
        o_result.seconds_count = r_seconds;
        o_result.accepted      = r_accept;
    end

endmodule

[design/tes_ctrl.sv]
// scheduler controller: sequences poll, push and remove over the datapath
module tes_ctrl import tes_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_mode,
    input  logic       i_out_free,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctx   <= C_REMOVE;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ctx   = r_ctx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_mode)
                        MODE_POLL:   n_state = S_POLL;
                        MODE_PUSH:   n_state = S_DSTART;
                        MODE_REMOVE: n_state = S_DSTART;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_POLL: n_state = i_stat.e_nz ? S_CHECK : S_POP;
            S_CHECK: begin
                if (i_stat.h_ge) begin
                    n_state = S_HDIV;
                end else if (i_stat.t_ge) begin
                    n_state = S_TDIV;
                end else if (i_stat.s_ge) begin
                    n_state = S_DAY;
                end else begin
                    n_state = S_POP;
                end
            end
            S_HDIV: if (!i_stat.div_busy) n_state = S_CD;
            S_TDIV: if (!i_stat.div_busy) n_state = S_FIN;
            S_CD: begin
                if (!i_stat.cd_more) begin
                    n_state = S_FIN;
                end else if (i_stat.cd_expired) begin
                    n_state = S_DROP;
                    n_ctx   = C_CD;
                end
            end
            S_DAY: begin
                if (i_stat.day_hit) begin
                    n_state = S_DROP;
                    n_ctx   = C_DAY;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP: n_state = S_FIN;
            S_DSTART: begin
                n_state = S_DROP;
                n_ctx   = (i_stat.mode == MODE_PUSH) ? C_PUSH : C_REMOVE;
            end
            S_DROP: begin
                if (!i_stat.drop_more) begin
                    case (r_ctx)
                        C_CD:    n_state = S_CD;
                        C_PUSH:  n_state = S_PUSH_DEC;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_PUSH_DEC: begin
                if (i_stat.delay_zero || i_stat.delay_full) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_PDIV;
                end
            end
            S_PDIV: if (!i_stat.div_busy) n_state = S_FIN;
            S_FIN: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load_item = i_in_valid;
            S_POLL: o_cmd.accum_add = i_stat.e_nz;
            S_CHECK: begin
                if (i_stat.h_ge) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_HUND;
                end else if (i_stat.t_ge) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_TENTH;
                end else if (i_stat.s_ge) begin
                    o_cmd.apply_sec = 1'b1;
                end
            end
            S_HDIV: o_cmd.apply_hund = !i_stat.div_busy;
            S_TDIV: o_cmd.apply_tenth = !i_stat.div_busy;
            S_CD: begin
                if (i_stat.cd_more) begin
                    if (i_stat.cd_expired) begin
                        o_cmd.drop_start = 1'b1;
                        o_cmd.code_sel   = CODE_ENTRY;
                    end else begin
                        o_cmd.cd_step = 1'b1;
                    end
                end
            end
            S_DAY: begin
                o_cmd.drop_start = i_stat.day_hit;
                o_cmd.code_sel   = CODE_DAY;
            end
            S_POP: o_cmd.pop_ready = i_stat.ready_nz;
            S_DSTART: begin
                o_cmd.drop_start = 1'b1;
                o_cmd.code_sel   = CODE_ITEM;
            end
            S_DROP: begin
                o_cmd.sel_drop = 1'b1;
                if (i_stat.drop_more) begin
                    o_cmd.drop_step = 1'b1;
                end else begin
                    o_cmd.drop_end   = 1'b1;
                    o_cmd.ready_push = (r_ctx == C_CD) || (r_ctx == C_DAY);
                end
            end
            S_PUSH_DEC: begin
                if (i_stat.delay_zero) begin
                    o_cmd.ready_push = 1'b1;
                    o_cmd.set_accept = 1'b1;
                end else if (i_stat.delay_full) begin
                    o_cmd.reject = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_DELAY;
                end
            end
            S_PDIV: begin
                o_cmd.div_sel     = DIV_DELAY;
                o_cmd.store_delay = !i_stat.div_busy;
            end
            S_FIN: o_cmd.out_load = i_out_free;
            default: ;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

[design/tick_event_scheduler.sv]
// top level of the tick event scheduler with its output register
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_beat  (t_in_beat)
//  out      output     o_out_valid / i_out_stall o_out_beat (t_out_beat)
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one beat at a time; a hundredth tick counts down the n delayed entries and drops each
// expired one, a second tick on a day boundary drops the day code, a remove and a push
// walk the n entries, a delayed push also divides its delay, and mode 3 goes straight
// to the result; each divide by ten or a hundred is a reciprocal multiply.
// synchronous active-low reset clears counters, queue levels and the output valid flag.
// a beat is taken while a result still waits in the output register; the block only
// holds at the end of the next beat until that register drains.
`include "tick_event_scheduler_macros.svh"
module tick_event_scheduler import tes_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_out_beat w_result;
    logic      w_out_free;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    assign w_out_free = !r_out_valid || !i_out_stall;

    tes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_beat.mode),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    tes_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (i_in_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_beat <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `TES_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `TES_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, w_out_free)
    `TES_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.out_load, o_out_valid)

endmodule
